[design/ycbcr_pair_to_rgba_converter_unit_macros.svh]
`ifndef YCBCR_PAIR_TO_RGBA_CONVERTER_UNIT_MACROS_SVH
`define YCBCR_PAIR_TO_RGBA_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk and skipped during rst.
`define YPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and skipped during rst.
`define YPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ycc2rgb_pkg.sv]
package ycc2rgb_pkg;

  localparam int FRAC_BITS   = 13;
  localparam int CHROMA_ZERO = 128;

  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int DIFF_W = PIX_W + 1;
  localparam int PROD_W = DIFF_W + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int IN_W   = 8 * PIX_W;
  localparam int OUT_W  = 8 * PIX_W;
  localparam int IDX_W  = 3;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

  // register indexes
  localparam logic [IDX_W-1:0] REG_LUMA_OFFSET    = 3'd0;
  localparam logic [IDX_W-1:0] REG_LUMA_GAIN      = 3'd1;
  localparam logic [IDX_W-1:0] REG_CB_TO_BLUE     = 3'd2;
  localparam logic [IDX_W-1:0] REG_CB_TO_GREEN    = 3'd3;
  localparam logic [IDX_W-1:0] REG_CR_TO_GREEN    = 3'd4;
  localparam logic [IDX_W-1:0] REG_CR_TO_RED      = 3'd5;
  localparam logic [IDX_W-1:0] REG_FORMAT_MODE    = 3'd6;
  localparam logic [IDX_W-1:0] REG_ALPHA_CONSTANT = 3'd7;

  // format_mode bits
  localparam int MODE_SHARE_CHROMA = 0;
  localparam int MODE_RED_FIRST    = 1;
  localparam int MODE_CONST_ALPHA  = 2;

  localparam logic [PIX_W-1:0]         RST_LUMA_OFFSET    = 8'd16;
  localparam logic signed [COEF_W-1:0] RST_LUMA_GAIN      = 16'sd9535;
  localparam logic signed [COEF_W-1:0] RST_CB_TO_BLUE     = 16'sd16531;
  localparam logic signed [COEF_W-1:0] RST_CB_TO_GREEN    = -16'sd3203;
  localparam logic signed [COEF_W-1:0] RST_CR_TO_GREEN    = -16'sd6660;
  localparam logic signed [COEF_W-1:0] RST_CR_TO_RED      = 16'sd13074;
  localparam logic [2:0]               RST_FORMAT_MODE    = 3'd1;
  localparam logic [PIX_W-1:0]         RST_ALPHA_CONSTANT = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0]         luma_offset;
    logic signed [COEF_W-1:0] luma_gain;
    logic signed [COEF_W-1:0] cb_to_blue;
    logic signed [COEF_W-1:0] cb_to_green;
    logic signed [COEF_W-1:0] cr_to_green;
    logic signed [COEF_W-1:0] cr_to_red;
    logic [2:0]               format_mode;
    logic [PIX_W-1:0]         alpha_constant;
  } cfg_t;

  typedef struct packed {
    logic load_prod;
    logic load_sum;
    logic load_out;
  } stage_en_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] alpha;
  } pix_t;

endpackage

[design/ycc2rgb_lane.sv]
module ycc2rgb_lane (
  input  logic                         clk,
  input  ycc2rgb_pkg::stage_en_t       en,
  input  ycc2rgb_pkg::cfg_t            cfg,
  input  logic [ycc2rgb_pkg::PIX_W-1:0] luma,
  input  logic [ycc2rgb_pkg::PIX_W-1:0] cb,
  input  logic [ycc2rgb_pkg::PIX_W-1:0] cr,
  input  logic [ycc2rgb_pkg::PIX_W-1:0] alpha,
  output ycc2rgb_pkg::pix_t            pix
);
  import ycc2rgb_pkg::*;

  logic signed [DIFF_W-1:0] y_c;
  logic signed [DIFF_W-1:0] cb_c;
  logic signed [DIFF_W-1:0] cr_c;

  logic signed [PROD_W-1:0] p_y;
  logic signed [PROD_W-1:0] p_cbb;
  logic signed [PROD_W-1:0] p_cbg;
  logic signed [PROD_W-1:0] p_crg;
  logic signed [PROD_W-1:0] p_crr;
  logic [PIX_W-1:0]         alpha_p;

  logic signed [SUM_W-1:0] sum_b;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_r;
  logic [PIX_W-1:0]        alpha_s;

  function automatic logic [PIX_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    q = s >>> FRAC_BITS;
    if (q < 0) begin
      return '0;
    end else if (q > $signed(SUM_W'(255))) begin
      return '1;
    end else begin
      return q[PIX_W-1:0];
    end
  endfunction

  assign y_c  = $signed({1'b0, luma}) - $signed({1'b0, cfg.luma_offset});
  assign cb_c = $signed({1'b0, cb}) - $signed(DIFF_W'(CHROMA_ZERO));
  assign cr_c = $signed({1'b0, cr}) - $signed(DIFF_W'(CHROMA_ZERO));

  always_ff @(posedge clk) begin
    if (en.load_prod) begin
      p_y     <= y_c * cfg.luma_gain;
      p_cbb   <= cb_c * cfg.cb_to_blue;
      p_cbg   <= cb_c * cfg.cb_to_green;
      p_crg   <= cr_c * cfg.cr_to_green;
      p_crr   <= cr_c * cfg.cr_to_red;
      alpha_p <= alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (en.load_sum) begin
      sum_b   <= SUM_W'(p_y) + SUM_W'(p_cbb) + ROUND_HALF;
      sum_g   <= SUM_W'(p_y) + SUM_W'(p_cbg) + SUM_W'(p_crg) + ROUND_HALF;
      sum_r   <= SUM_W'(p_y) + SUM_W'(p_crr) + ROUND_HALF;
      alpha_s <= alpha_p;
    end
  end

  assign pix.blue  = clamp_channel(sum_b);
  assign pix.green = clamp_channel(sum_g);
  assign pix.red   = clamp_channel(sum_r);
  assign pix.alpha = alpha_s;

endmodule

[design/ycc2rgb_merge.sv]
module ycc2rgb_merge (
  input  logic                          clk,
  input  ycc2rgb_pkg::stage_en_t        en,
  input  ycc2rgb_pkg::cfg_t             cfg,
  input  ycc2rgb_pkg::pix_t             pix_first,
  input  ycc2rgb_pkg::pix_t             pix_second,
  output logic [ycc2rgb_pkg::OUT_W-1:0] tdata
);
  import ycc2rgb_pkg::*;

  logic                red_first;
  logic                const_alpha;
  logic [OUT_W/2-1:0]  word_first;
  logic [OUT_W/2-1:0]  word_second;

  function automatic logic [OUT_W/2-1:0] pack_pixel(input pix_t p, input logic rf,
                                                      input logic ca,
                                                      input logic [PIX_W-1:0] ac);
    logic [PIX_W-1:0] lead;
    logic [PIX_W-1:0] trail;
    logic [PIX_W-1:0] a;
    lead  = rf ? p.red : p.blue;
    trail = rf ? p.blue : p.red;
    a     = ca ? ac : p.alpha;
    return {a, trail, p.green, lead};
  endfunction

  assign red_first   = cfg.format_mode[MODE_RED_FIRST];
  assign const_alpha = cfg.format_mode[MODE_CONST_ALPHA];
  assign word_first  = pack_pixel(pix_first, red_first, const_alpha, cfg.alpha_constant);
  assign word_second = pack_pixel(pix_second, red_first, const_alpha, cfg.alpha_constant);

  always_ff @(posedge clk) begin
    if (en.load_out) begin
      tdata <= {word_second, word_first};
    end
  end

endmodule

[design/ycbcr_pair_to_rgba_converter_unit.sv]
// YCbCr pixel-pair to 4-byte color converter.
// Input stream s_*: one transaction carries two adjacent pixels (two lumas,
// chroma of each pixel, two alphas). Output stream m_*: one transaction per
// input holding both pixels as lead, green, trail, alpha bytes.
// Configuration channel cfg_*: index selects one of eight registers, taken
// at any edge with cfg_valid high (cfg_ready is always high); write only
// while no transaction is in flight.
// Two identical pixel lanes run side by side: a multiply stage, a sum and
// round stage, then a clamp that feeds the shared byte-ordering output
// register. An accepted pair passes the multiply, sum and output registers.
// Throughput is one pixel pair per clock while m_tready is high; each stage
// loads whenever the stage after it is empty or emptying, so bubbles close
// up under stall. When m_tready is low the output register holds its data,
// and s_tready drops only once all three stages hold a transaction.
// Synchronous reset empties the pipeline and loads the default BT.601
// studio-range coefficients, shared chroma, blue-first order, input alpha.
module ycbcr_pair_to_rgba_converter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // luma_first, luma_second, cb_first, cr_first, cb_second, cr_second,
  // alpha_first, alpha_second
  input  logic [ycc2rgb_pkg::IN_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // first_lead, first_green, first_trail, first_alpha, second_lead,
  // second_green, second_trail, second_alpha
  output logic [ycc2rgb_pkg::OUT_W-1:0] m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ycc2rgb_pkg::IDX_W-1:0] cfg_index,
  input  logic [ycc2rgb_pkg::COEF_W-1:0] cfg_data
);
  import ycc2rgb_pkg::*;

  `include "ycbcr_pair_to_rgba_converter_unit_macros.svh"

  cfg_t      cfg;
  stage_en_t en;
  logic      v1;
  logic      v2;
  logic      ready2;
  logic      out_ok;
  pix_t      pix_first;
  pix_t      pix_second;

  logic [PIX_W-1:0] cb2;
  logic [PIX_W-1:0] cr2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.luma_offset    <= RST_LUMA_OFFSET;
      cfg.luma_gain      <= RST_LUMA_GAIN;
      cfg.cb_to_blue     <= RST_CB_TO_BLUE;
      cfg.cb_to_green    <= RST_CB_TO_GREEN;
      cfg.cr_to_green    <= RST_CR_TO_GREEN;
      cfg.cr_to_red      <= RST_CR_TO_RED;
      cfg.format_mode    <= RST_FORMAT_MODE;
      cfg.alpha_constant <= RST_ALPHA_CONSTANT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LUMA_OFFSET:    cfg.luma_offset    <= cfg_data[PIX_W-1:0];
        REG_LUMA_GAIN:      cfg.luma_gain      <= cfg_data;
        REG_CB_TO_BLUE:     cfg.cb_to_blue     <= cfg_data;
        REG_CB_TO_GREEN:    cfg.cb_to_green    <= cfg_data;
        REG_CR_TO_GREEN:    cfg.cr_to_green    <= cfg_data;
        REG_CR_TO_RED:      cfg.cr_to_red      <= cfg_data;
        REG_FORMAT_MODE:    cfg.format_mode    <= cfg_data[2:0];
        REG_ALPHA_CONSTANT: cfg.alpha_constant <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake: a stage loads when the one after it is empty or emptying
  assign out_ok   = !m_tvalid || m_tready;
  assign ready2   = !v2 || out_ok;
  assign s_tready = !v1 || ready2;

  assign en.load_prod = s_tvalid && s_tready;
  assign en.load_sum  = v1 && ready2;
  assign en.load_out  = v2 && out_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        v1 <= s_tvalid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (out_ok) begin
        m_tvalid <= v2;
      end
    end
  end

  // in shared mode the second pixel reuses the first pixel's chroma
  assign cb2 = cfg.format_mode[MODE_SHARE_CHROMA] ? s_tdata[23:16] : s_tdata[39:32];
  assign cr2 = cfg.format_mode[MODE_SHARE_CHROMA] ? s_tdata[31:24] : s_tdata[47:40];

  ycc2rgb_lane u_lane_first (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .luma  (s_tdata[7:0]),
    .cb    (s_tdata[23:16]),
    .cr    (s_tdata[31:24]),
    .alpha (s_tdata[55:48]),
    .pix   (pix_first)
  );

  ycc2rgb_lane u_lane_second (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .luma  (s_tdata[15:8]),
    .cb    (cb2),
    .cr    (cr2),
    .alpha (s_tdata[63:56]),
    .pix   (pix_second)
  );

  ycc2rgb_merge u_merge (
    .clk        (clk),
    .en         (en),
    .cfg        (cfg),
    .pix_first  (pix_first),
    .pix_second (pix_second),
    .tdata      (m_tdata)
  );

  `YPR_ASSERT_IMP(a_ready_low_full, !s_tready, v1 && v2 && m_tvalid && !m_tready, "input stalled with a free stage")
  `YPR_ASSERT_NXT(a_accept_fills, s_tvalid && s_tready, v1, "accepted transaction lost in stage one")
  `YPR_ASSERT_NXT(a_sum_advances, v2 && out_ok, m_tvalid, "sum stage did not reach the output")
  `YPR_ASSERT_NXT(a_cfg_alpha, cfg_valid && cfg_index == REG_ALPHA_CONSTANT, cfg.alpha_constant == $past(cfg_data[PIX_W-1:0]), "alpha constant write lost")

endmodule
